/* hw/rtl/v3n_pkg.sv */
package v3n_pkg;

  localparam int OUT_FRAC_BITS = 30;
  localparam int COMP_W        = 32;
  localparam int MAG_W         = COMP_W;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int SUM_W         = SQ_W;
  localparam int STEPS         = OUT_FRAC_BITS + 2;
  localparam int X_SHIFT       = 2 * OUT_FRAC_BITS + 2;
  localparam int RW            = SQ_W + X_SHIFT + 2;
  localparam int LATENCY       = STEPS + 3;

  typedef struct packed {
    logic signed [COMP_W-1:0] in_x;
    logic signed [COMP_W-1:0] in_y;
    logic signed [COMP_W-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] unit_x;
    logic signed [COMP_W-1:0] unit_y;
    logic signed [COMP_W-1:0] unit_z;
    logic                     was_zero;
  } out_t;

  typedef struct packed {
    logic [RW-1:0]    r;
    logic [RW-1:0]    p;
    logic [STEPS-1:0] v;
  } lane_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [SUM_W-1:0] s;
    lane_t [2:0]      ln;
  } stg_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0][SQ_W-1:0]  c2;
  } sq_t;

endpackage

/* hw/rtl/vector3_normalize_core.sv */
// Throughput: one transaction per cycle unless the output stalls.
// The root search runs as 32 pipelined stages, one result bit per stage,
// each a single wide subtract and compare per lane.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module vector3_normalize_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  v3n_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output v3n_pkg::out_t  out_data
);
  import v3n_pkg::*;

  logic                  en;
  logic [STEPS+1:0]      vld_r;
  sq_t                   sq_r;
  sq_t                   sq_nxt;
  stg_t                  stg_r [0:STEPS];
  stg_t                  stg0_nxt;
  out_t                  out_r;
  out_t                  out_nxt;
  logic                  out_valid_r;
  logic [2:0][COMP_W-1:0] comp;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign comp      = {in_data.in_x, in_data.in_y, in_data.in_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt.neg[i] = comp[i][COMP_W-1];
      sq_nxt.mag[i] = comp[i][COMP_W-1] ? (~comp[i] + MAG_W'(1)) : comp[i];
      sq_nxt.c2[i]  = SQ_W'(sq_nxt.mag[i]) * SQ_W'(sq_nxt.mag[i]);
    end
  end

  always_comb begin
    stg0_nxt.neg  = sq_r.neg;
    stg0_nxt.s    = sq_r.c2[0] + sq_r.c2[1] + sq_r.c2[2];
    stg0_nxt.zero = (stg0_nxt.s == '0);
    for (int i = 0; i < 3; i++) begin
      stg0_nxt.ln[i].r = RW'(sq_r.c2[i]) << X_SHIFT;
      stg0_nxt.ln[i].p = '0;
      stg0_nxt.ln[i].v = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= sq_nxt;
      stg_r[0] <= stg0_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = STEPS - 1 - k;
    stg_t step_nxt;

    always_comb begin
      logic [RW-1:0] term;
      logic [RW-1:0] diff;
      step_nxt = stg_r[k];
      for (int i = 0; i < 3; i++) begin
        term = (stg_r[k].ln[i].p << (B + 1)) + (RW'(stg_r[k].s) << (2 * B));
        diff = stg_r[k].ln[i].r - term;
        if (!diff[RW-1] && (term <= stg_r[k].ln[i].r)) begin
          step_nxt.ln[i].r    = diff;
          step_nxt.ln[i].p    = stg_r[k].ln[i].p + (RW'(stg_r[k].s) << B);
          step_nxt.ln[i].v[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1] <= step_nxt;
      end
    end
  end

  always_comb begin
    logic [STEPS-1:0]  q;
    logic [COMP_W-1:0] uq;
    logic [2:0][COMP_W-1:0] res;
    for (int i = 0; i < 3; i++) begin
      q = STEPS'(({1'b0, stg_r[STEPS].ln[i].v} + (STEPS+1)'(1)) >> 1);
      if (q > (STEPS'(1) << OUT_FRAC_BITS)) begin
        q = STEPS'(1) << OUT_FRAC_BITS;
      end
      uq = COMP_W'(q);
      if (stg_r[STEPS].zero) begin
        res[i] = '0;
      end else begin
        res[i] = stg_r[STEPS].neg[i] ? (~uq + COMP_W'(1)) : uq;
      end
    end
    out_nxt.unit_x   = res[2];
    out_nxt.unit_y   = res[1];
    out_nxt.unit_z   = res[0];
    out_nxt.was_zero = stg_r[STEPS].zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[STEPS:0], in_valid};
      out_valid_r <= vld_r[STEPS+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTH
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_zero |->
      out_data.unit_x == '0 && out_data.unit_y == '0 && out_data.unit_z == '0)
    else $error("zero vector with nonzero result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.unit_x <= 32'sd1073741824 && out_data.unit_x >= -32'sd1073741824 &&
      out_data.unit_y <= 32'sd1073741824 && out_data.unit_y >= -32'sd1073741824 &&
      out_data.unit_z <= 32'sd1073741824 && out_data.unit_z >= -32'sd1073741824)
    else $error("result out of unit range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline advanced under stall");
`endif

endmodule
